// ===== hdl/efd_pkg.sv =====
`default_nettype none

package efd_pkg;

    // Mode codes, as reported on the result channel
    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_CALIB   = 3'd1;
    localparam logic [2:0] MODE_IDLE    = 3'd2;
    localparam logic [2:0] MODE_MOVING  = 3'd3;
    localparam logic [2:0] MODE_STOPPED = 3'd4;
    localparam logic [2:0] MODE_ERROR   = 3'd5;

    // Event codes on the input channel
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_CALL       = 3'd1;
    localparam logic [2:0] CMD_STOPPED    = 3'd2;
    localparam logic [2:0] CMD_CAL_SENSOR = 3'd3;
    localparam logic [2:0] CMD_OTH_SENSOR = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_FLOOR_COUNT = 3'd0;
    localparam logic [2:0] REG_DWELL_TICKS = 3'd1;
    localparam logic [2:0] REG_FLOOR0_POS  = 3'd2;

    localparam logic [2:0]  FLOOR_COUNT_RST = 3'd4;
    localparam logic [15:0] DWELL_TICKS_RST = 16'd100;
    localparam logic [15:0] FLOOR_POS_RST [4] = '{16'd0, 16'd1000, 16'd2000, 16'd3000};

    // Sequencer -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_load;
        logic scan_step;
        logic commit;
        logic load_out;
    } ctrl_t;

    // Datapath -> sequencer
    typedef struct packed {
        logic need_choose;
        logic choose_ok;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/elevator_floor_dispatcher.sv =====
`default_nettype none

// Elevator dispatcher for up to MAX_FLOORS floors: each input beat is one
// event (step tick, floor call, stepper stopped, calibration sensor, other
// sensor) and yields exactly one result beat with the mode, one-shot
// stepper commands (target, seek home, position reset) and the car status.
// Next stop follows a SCAN rule: nearest pending floor in the current
// direction, then the opposite one, else floor 0. One event is handled at a
// time: capture, execute, then the result; if a search is due, a prep
// state checks that the mode takes a new stop, and if it does, the scan and
// a commit follow. The scan tests one floor per cycle in each direction.
// The result sits in an output register, so the next event is taken while
// it waits; that next event then holds in its last cycle until the register
// is free. The user must write configuration via cfg_we/cfg_index/cfg_data
// only while no event is in flight; the block does not enforce this, and
// indexes past the last floor position are ignored.

module elevator_floor_dispatcher #(
    parameter int MAX_FLOORS = 4,
    parameter int POS_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    // event beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [1:0]  s_floor,
    input  wire logic        s_sensor_pressed,
    input  wire logic [16:0] s_position,

    // result beats
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_mode,
    output logic             m_target_valid,
    output logic [15:0]      m_target_position,
    output logic             m_seek_home,
    output logic             m_stepper_reset,
    output logic             m_started,
    output logic             m_arrived,
    output logic [1:0]       m_current_floor,
    output logic             m_floor_known,
    output logic [1:0]       m_destination,
    output logic [3:0]       m_pending_mask
);

    efd_pkg::ctrl_t ctrl;
    efd_pkg::stat_t stat;

    // sequencer: capture, execute, scan, commit, hand off result
    efd_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // car state, config registers, floor scanner and output register
    efd_datapath #(
        .MAX_FLOORS (MAX_FLOORS),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_command         (s_command),
        .s_floor           (s_floor),
        .s_sensor_pressed  (s_sensor_pressed),
        .s_position        (s_position),
        .ctrl              (ctrl),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mode            (m_mode),
        .m_target_valid    (m_target_valid),
        .m_target_position (m_target_position),
        .m_seek_home       (m_seek_home),
        .m_stepper_reset   (m_stepper_reset),
        .m_started         (m_started),
        .m_arrived         (m_arrived),
        .m_current_floor   (m_current_floor),
        .m_floor_known     (m_floor_known),
        .m_destination     (m_destination),
        .m_pending_mask    (m_pending_mask)
    );

endmodule

`default_nettype wire

// ===== hdl/efd_controller.sv =====
`default_nettype none

module efd_controller (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  efd_pkg::stat_t     stat,
    output efd_pkg::ctrl_t     ctrl
);

    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_WAIT);

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_WAIT: begin
                if (s_valid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctrl.exec  = 1'b1;
                state_next = stat.need_choose ? ST_PREP : ST_DONE;
            end
            ST_PREP: begin
                if (stat.choose_ok) begin
                    ctrl.scan_load = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_hit || stat.scan_end) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                ctrl.commit = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed next cycle");

    a_commit_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) |-> ($past(state_reg) == ST_SCAN))
        else $error("commit without a scan");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !stat.out_free) |=> (state_reg == ST_DONE))
        else $error("result dropped while output register full");

endmodule

`default_nettype wire

// ===== hdl/efd_datapath.sv =====
`default_nettype none

module efd_datapath #(
    parameter int MAX_FLOORS = 4,
    parameter int POS_BITS   = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    input  wire logic [2:0]    s_command,
    input  wire logic [1:0]    s_floor,
    input  wire logic          s_sensor_pressed,
    input  wire logic [16:0]   s_position,
    input  efd_pkg::ctrl_t     ctrl,
    output efd_pkg::stat_t     stat,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_mode,
    output logic               m_target_valid,
    output logic [15:0]        m_target_position,
    output logic               m_seek_home,
    output logic               m_stepper_reset,
    output logic               m_started,
    output logic               m_arrived,
    output logic [1:0]         m_current_floor,
    output logic               m_floor_known,
    output logic [1:0]         m_destination,
    output logic [3:0]         m_pending_mask
);

    // stored target is clipped to the stepper's position width
    localparam int DEST_W = (POS_BITS < 16) ? POS_BITS : 16;

    // configuration
    logic [2:0]  floor_count_reg;
    logic [15:0] dwell_ticks_reg;
    logic [15:0] floor_pos_reg [MAX_FLOORS];

    // captured beat
    logic [2:0]  cmd_reg;
    logic [1:0]  fl_reg;
    logic        pressed_reg;
    logic [16:0] pos_reg;

    // car state
    logic [2:0]            mode_reg,       mode_next;
    logic                  going_down_reg, going_down_next;
    logic [MAX_FLOORS-1:0] pending_reg,    pending_next;
    logic [1:0]            last_reg,       last_next;
    logic                  known_reg,      known_next;
    logic [1:0]            dest_reg,       dest_next;
    logic [DEST_W-1:0]     dest_pos_reg,   dest_pos_next;
    logic [15:0]           dwell_reg,      dwell_next;

    // per-beat flags
    logic tv_reg,      tv_next;
    logic seek_reg,    seek_next;
    logic srst_reg,    srst_next;
    logic started_reg, started_next;
    logic arrived_reg, arrived_next;

    // floor scan
    logic [2:0] idx_reg,   idx_next;
    logic       phase_reg, phase_next;
    logic [1:0] nf_reg,    nf_next;
    logic       found_reg, found_next;

    logic m_valid_reg;

    logic [2:0]  cnt;
    logic [3:0]  pend4;
    logic [2:0]  up_start;
    logic [2:0]  dn_start;
    logic        cur_dir;
    logic        live;
    logic        hit;
    logic        pos_match;
    logic [15:0] sel_pos;

    // floor count clamped to 1..MAX_FLOORS
    always_comb begin
        if (floor_count_reg == 3'd0) begin
            cnt = 3'd1;
        end else if (floor_count_reg > 3'(MAX_FLOORS)) begin
            cnt = 3'(MAX_FLOORS);
        end else begin
            cnt = floor_count_reg;
        end
    end

    assign pend4     = 4'(pending_reg);
    assign up_start  = known_reg ? ({1'b0, last_reg} + 3'd1) : 3'd0;
    assign dn_start  = {1'b0, last_reg} - 3'd1;
    assign cur_dir   = going_down_reg ^ phase_reg;
    // unknown floor: car sits below floor 0, nothing lies downward;
    // going down, floors at or above the count are passed over
    assign live      = cur_dir ? (known_reg && !idx_reg[2])
                               : (idx_reg < cnt);
    assign hit       = live && (idx_reg < cnt) && pend4[idx_reg[1:0]];
    assign pos_match = !pos_reg[16] && (pos_reg[15:0] == 16'(dest_pos_reg));

    always_comb begin
        sel_pos = '0;
        for (int i = 0; i < MAX_FLOORS; i++) begin
            if (nf_reg == 2'(i)) begin
                sel_pos = floor_pos_reg[i];
            end
        end
    end

    always_comb begin
        stat.choose_ok = (mode_reg == efd_pkg::MODE_IDLE) ||
                         (mode_reg == efd_pkg::MODE_MOVING);
        stat.scan_hit  = hit;
        stat.scan_end  = !live && phase_reg;
        stat.out_free  = !m_valid_reg || m_ready;
        unique case (cmd_reg)
            efd_pkg::CMD_TICK:
                stat.need_choose = (mode_reg == efd_pkg::MODE_INIT && pressed_reg) ||
                                   (mode_reg == efd_pkg::MODE_STOPPED && dwell_reg <= 16'd1);
            efd_pkg::CMD_CALL:       stat.need_choose = ({1'b0, fl_reg} < cnt);
            efd_pkg::CMD_CAL_SENSOR: stat.need_choose = (mode_reg == efd_pkg::MODE_CALIB);
            default:                 stat.need_choose = 1'b0;
        endcase
    end

    always_comb begin
        mode_next       = mode_reg;
        going_down_next = going_down_reg;
        pending_next    = pending_reg;
        last_next       = last_reg;
        known_next      = known_reg;
        dest_next       = dest_reg;
        dest_pos_next   = dest_pos_reg;
        dwell_next      = dwell_reg;
        tv_next         = tv_reg;
        seek_next       = seek_reg;
        srst_next       = srst_reg;
        started_next    = started_reg;
        arrived_next    = arrived_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        nf_next         = nf_reg;
        found_next      = found_reg;

        if (ctrl.capture) begin
            tv_next      = 1'b0;
            seek_next    = 1'b0;
            srst_next    = 1'b0;
            started_next = 1'b0;
            arrived_next = 1'b0;
        end

        if (ctrl.exec) begin
            unique case (cmd_reg)
                efd_pkg::CMD_TICK: begin
                    if (mode_reg == efd_pkg::MODE_INIT) begin
                        if (pressed_reg) begin
                            srst_next       = 1'b1;
                            mode_next       = efd_pkg::MODE_IDLE;
                            known_next      = 1'b0;
                            pending_next[0] = 1'b1;
                        end else begin
                            seek_next = 1'b1;
                            mode_next = efd_pkg::MODE_CALIB;
                        end
                    end else if (mode_reg == efd_pkg::MODE_STOPPED) begin
                        if (dwell_reg <= 16'd1) begin
                            dwell_next = '0;
                            mode_next  = efd_pkg::MODE_IDLE;
                        end else begin
                            dwell_next = dwell_reg - 16'd1;
                        end
                    end
                end
                efd_pkg::CMD_CALL: begin
                    for (int i = 0; i < MAX_FLOORS; i++) begin
                        if ({1'b0, fl_reg} < cnt && fl_reg == 2'(i)) begin
                            pending_next[i] = 1'b1;
                        end
                    end
                end
                efd_pkg::CMD_STOPPED: begin
                    if (mode_reg != efd_pkg::MODE_MOVING || !pos_match) begin
                        mode_next = efd_pkg::MODE_ERROR;
                    end else begin
                        mode_next    = efd_pkg::MODE_STOPPED;
                        last_next    = dest_reg;
                        known_next   = 1'b1;
                        dwell_next   = dwell_ticks_reg;
                        arrived_next = 1'b1;
                        for (int i = 0; i < MAX_FLOORS; i++) begin
                            if (dest_reg == 2'(i)) begin
                                pending_next[i] = 1'b0;
                            end
                        end
                    end
                end
                efd_pkg::CMD_CAL_SENSOR: begin
                    srst_next = 1'b1;
                    if (mode_reg != efd_pkg::MODE_CALIB) begin
                        mode_next = efd_pkg::MODE_ERROR;
                    end else begin
                        mode_next       = efd_pkg::MODE_IDLE;
                        known_next      = 1'b0;
                        pending_next[0] = 1'b1;
                    end
                end
                efd_pkg::CMD_OTH_SENSOR: begin
                    srst_next = 1'b1;
                    mode_next = efd_pkg::MODE_ERROR;
                end
                default: begin
                end
            endcase
        end

        if (ctrl.scan_load) begin
            phase_next = 1'b0;
            found_next = 1'b0;
            idx_next   = going_down_reg ? dn_start : up_start;
        end

        if (ctrl.scan_step) begin
            if (hit) begin
                nf_next    = idx_reg[1:0];
                found_next = 1'b1;
            end else if (live) begin
                idx_next = cur_dir ? (idx_reg - 3'd1) : (idx_reg + 3'd1);
            end else if (!phase_reg) begin
                phase_next = 1'b1;
                idx_next   = going_down_reg ? up_start : dn_start;
            end else begin
                // nothing pending either way: head for floor 0
                nf_next    = 2'd0;
                found_next = !known_reg || (last_reg != 2'd0);
            end
        end

        if (ctrl.commit) begin
            if (found_reg && !(mode_reg == efd_pkg::MODE_MOVING && nf_reg == dest_reg)) begin
                mode_next       = efd_pkg::MODE_MOVING;
                dest_next       = nf_reg;
                going_down_next = known_reg ? !(nf_reg > last_reg) : 1'b1;
                dest_pos_next   = DEST_W'(sel_pos);
                tv_next         = 1'b1;
                started_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_count_reg <= efd_pkg::FLOOR_COUNT_RST;
            dwell_ticks_reg <= efd_pkg::DWELL_TICKS_RST;
            for (int i = 0; i < MAX_FLOORS; i++) begin
                floor_pos_reg[i] <= efd_pkg::FLOOR_POS_RST[i];
            end
            mode_reg       <= efd_pkg::MODE_INIT;
            going_down_reg <= 1'b0;
            pending_reg    <= '0;
            last_reg       <= '0;
            known_reg      <= 1'b1;
            dest_reg       <= '0;
            dest_pos_reg   <= '0;
            dwell_reg      <= '0;
            tv_reg         <= 1'b0;
            seek_reg       <= 1'b0;
            srst_reg       <= 1'b0;
            started_reg    <= 1'b0;
            arrived_reg    <= 1'b0;
            phase_reg      <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == efd_pkg::REG_FLOOR_COUNT) begin
                    floor_count_reg <= cfg_data[2:0];
                end
                if (cfg_index == efd_pkg::REG_DWELL_TICKS) begin
                    dwell_ticks_reg <= cfg_data;
                end
                for (int i = 0; i < MAX_FLOORS; i++) begin
                    if (cfg_index == efd_pkg::REG_FLOOR0_POS + 3'(i)) begin
                        floor_pos_reg[i] <= cfg_data;
                    end
                end
            end
            mode_reg       <= mode_next;
            going_down_reg <= going_down_next;
            pending_reg    <= pending_next;
            last_reg       <= last_next;
            known_reg      <= known_next;
            dest_reg       <= dest_next;
            dest_pos_reg   <= dest_pos_next;
            dwell_reg      <= dwell_next;
            tv_reg         <= tv_next;
            seek_reg       <= seek_next;
            srst_reg       <= srst_next;
            started_reg    <= started_next;
            arrived_reg    <= arrived_next;
            phase_reg      <= phase_next;
            found_reg      <= found_next;
            if (ctrl.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        nf_reg  <= nf_next;
        if (ctrl.capture) begin
            cmd_reg     <= s_command;
            fl_reg      <= s_floor;
            pressed_reg <= s_sensor_pressed;
            pos_reg     <= s_position;
        end
        if (ctrl.load_out) begin
            m_mode            <= mode_reg;
            m_target_valid    <= tv_reg;
            m_target_position <= tv_reg ? 16'(dest_pos_reg) : 16'd0;
            m_seek_home       <= seek_reg;
            m_stepper_reset   <= srst_reg;
            m_started         <= started_reg;
            m_arrived         <= arrived_reg;
            m_current_floor   <= last_reg;
            m_floor_known     <= known_reg;
            m_destination     <= dest_reg;
            m_pending_mask    <= pend4;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
